// ===== hw/rtl/detection_query_decode_assert.svh =====
// Assertion shorthands used by the checker file.
// All of them sample on clk and are disabled while arst_n is low.
`ifndef DETECTION_QUERY_DECODE_ASSERT_SVH
`define DETECTION_QUERY_DECODE_ASSERT_SVH

// Same-cycle implication.
`define DQD_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dqd assertion failed");

// Next-cycle implication.
`define DQD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dqd assertion failed");

`endif

// ===== hw/rtl/dqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dqd_pkg;

	// Register indexes on the configuration port
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 24;
	localparam logic [CfgAddrW-1:0] CFG_INPUT_WIDTH     = 3'd0;
	localparam logic [CfgAddrW-1:0] CFG_INPUT_HEIGHT    = 3'd1;
	localparam logic [CfgAddrW-1:0] CFG_SCALE_X         = 3'd2;
	localparam logic [CfgAddrW-1:0] CFG_SCALE_Y         = 3'd3;
	localparam logic [CfgAddrW-1:0] CFG_SCORE_THRESHOLD = 3'd4;

	localparam logic [12:0] INPUT_WIDTH_RST     = 13'd640;
	localparam logic [12:0] INPUT_HEIGHT_RST    = 13'd640;
	localparam logic [23:0] SCALE_X_RST         = 24'd65536;
	localparam logic [23:0] SCALE_Y_RST         = 24'd65536;
	localparam logic [15:0] SCORE_THRESHOLD_RST = 16'd32768;

	// Best class marker meaning no class seen yet
	localparam logic [7:0] NO_CLASS = 8'hFF;

	// Queue between front and back
	localparam int QDepth = 4;
	localparam int QAddrW = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// round(65536 * sigmoid(k/4)), k = 0..32
	localparam logic [15:0] SIG_TABLE [0:32] = '{
		16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941, 16'd53581,
		16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61598, 16'd62428, 16'd63090,
		16'd63615, 16'd64030, 16'd64357, 16'd64614, 16'd64816, 16'd64974, 16'd65097,
		16'd65194, 16'd65269, 16'd65328, 16'd65374, 16'd65410, 16'd65438, 16'd65459,
		16'd65476, 16'd65489, 16'd65500, 16'd65508, 16'd65514
	};

	typedef struct packed {
		logic signed [15:0] logit;
		logic               last_class;
		logic [15:0]        center_x;
		logic [15:0]        center_y;
		logic [15:0]        box_w;
		logic [15:0]        box_h;
	} in_item_t;

	typedef struct packed {
		logic [6:0]         det_class;
		logic [15:0]        confidence;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0]        width_px;
		logic [14:0]        height_px;
	} out_item_t;

	typedef struct packed {
		logic [12:0] input_width;
		logic [12:0] input_height;
		logic [23:0] scale_x;
		logic [23:0] scale_y;
		logic [15:0] score_threshold;
	} cfg_t;

	// One detection waiting for box decode
	typedef struct packed {
		logic [6:0]  det_class;
		logic [15:0] confidence;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] box_w;
		logic [15:0] box_h;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL1,
		BK_MUL2,
		BK_FIN
	} back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dqd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dqd_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire dqd_pkg::job_t               push_data,
	input  wire logic                        pop,
	output dqd_pkg::job_t                    head,
	output logic                             empty,
	output logic [dqd_pkg::QCntW-1:0]        count
);

	dqd_pkg::job_t                  mem_q [dqd_pkg::QDepth];
	logic [dqd_pkg::QAddrW-1:0]     wr_ptr_q;
	logic [dqd_pkg::QAddrW-1:0]     rd_ptr_q;
	logic [dqd_pkg::QCntW-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/dqd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dqd_front #(
	parameter int MAX_CLASSES = 128
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire dqd_pkg::in_item_t           item,
	input  wire logic [15:0]                 score_threshold,
	input  wire logic [dqd_pkg::QCntW-1:0]   q_count,
	output logic                             push,
	output dqd_pkg::job_t                    push_data
);

	localparam int CntW = $clog2(MAX_CLASSES + 1);

	// Stage 1: table lookup
	logic        valid_s1;
	logic        last_s1;
	logic        neg_s1;
	logic [15:0] base_s1;
	logic [15:0] diff_s1;
	logic [5:0]  frac_s1;
	logic [15:0] cx_s1, cy_s1, bw_s1, bh_s1;

	// Stage 2: interpolated score
	logic        valid_s2;
	logic        last_s2;
	logic [15:0] score_s2;
	logic [15:0] cx_s2, cy_s2, bw_s2, bh_s2;

	// Running query state
	logic [15:0]     best_score_q;
	logic [7:0]      best_class_q;
	logic [CntW-1:0] count_q;

	logic        accept;
	logic [16:0] mag;
	logic        sat;
	logic [5:0]  idx;
	logic [15:0] lo_val, hi_val;
	logic [21:0] interp;
	logic [15:0] s_val;
	logic [15:0] score;
	logic [1:0]  lasts_in_flight;
	logic        in_range;
	logic        better;
	logic [15:0] nxt_score;
	logic [7:0]  nxt_class;

	// Reserve a queue slot for every last item in flight
	assign lasts_in_flight = {1'b0, valid_s1 & last_s1} + {1'b0, valid_s2 & last_s2};
	assign item_stall = ({1'b0, q_count} + (dqd_pkg::QCntW + 1)'(lasts_in_flight))
		>= (dqd_pkg::QCntW + 1)'(dqd_pkg::QDepth);
	assign accept = item_valid & ~item_stall;

	assign mag    = item.logit[15] ? (17'd0 - {item.logit[15], item.logit})
		: {1'b0, item.logit};
	assign sat    = |mag[16:11];
	assign idx    = {1'b0, mag[10:6]};
	assign lo_val = dqd_pkg::SIG_TABLE[idx];
	assign hi_val = dqd_pkg::SIG_TABLE[idx + 6'd1];

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= item.last_class;
			neg_s1  <= item.logit[15];
			base_s1 <= sat ? dqd_pkg::SIG_TABLE[32] : lo_val;
			diff_s1 <= sat ? 16'd0 : (hi_val - lo_val);
			frac_s1 <= mag[5:0];
			cx_s1   <= item.center_x;
			cy_s1   <= item.center_y;
			bw_s1   <= item.box_w;
			bh_s1   <= item.box_h;
		end
		if (valid_s1) begin
			last_s2  <= last_s1;
			score_s2 <= score;
			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
			bw_s2    <= bw_s1;
			bh_s2    <= bh_s1;
		end
	end

	assign interp = diff_s1 * frac_s1;
	assign s_val  = base_s1 + interp[21:6];
	assign score  = neg_s1 ? 16'(17'h10000 - {1'b0, s_val}) : s_val;

	// First strictly larger score wins
	assign in_range  = count_q < CntW'(MAX_CLASSES);
	assign better    = in_range && (score_s2 > best_score_q);
	assign nxt_score = better ? score_s2 : best_score_q;
	assign nxt_class = better ? 8'(count_q) : best_class_q;

	assign push = valid_s2 && last_s2 && (nxt_class != dqd_pkg::NO_CLASS)
		&& (nxt_class != 8'd0) && (nxt_score >= score_threshold);

	always_comb begin
		push_data.det_class  = 7'(nxt_class - 8'd1);
		push_data.confidence = nxt_score;
		push_data.center_x   = cx_s2;
		push_data.center_y   = cy_s2;
		push_data.box_w      = bw_s2;
		push_data.box_h      = bh_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			best_score_q <= '0;
			best_class_q <= dqd_pkg::NO_CLASS;
			count_q      <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (last_s2) begin
					// end of query: drop the running maximum
					best_score_q <= '0;
					best_class_q <= dqd_pkg::NO_CLASS;
					count_q      <= '0;
				end else begin
					best_score_q <= nxt_score;
					best_class_q <= nxt_class;
					if (in_range) begin
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dqd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dqd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dqd_pkg::cfg_t       cfg,
	input  wire dqd_pkg::job_t       head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output dqd_pkg::out_item_t       result
);

	dqd_pkg::back_state_t state_q, state_d;
	dqd_pkg::job_t        job_q;
	dqd_pkg::out_item_t   result_q;
	logic                 result_valid_q;

	logic signed [31:0] lx_p1_q, ty_p1_q;
	logic [28:0]        wx_p1_q, hy_p1_q;
	logic signed [56:0] lx_p2_q, ty_p2_q;
	logic [52:0]        wx_p2_q, hy_p2_q;

	logic signed [17:0] dx, dy;
	logic               out_free;
	logic               load_out;

	function automatic logic signed [15:0] sat_corner(input logic signed [56:0] p);
		logic signed [56:0] adj;
		logic signed [23:0] q;
		// truncate toward zero: bias negatives before the shift
		adj = p + (p[56] ? 57'sh1_FFFF_FFFF : 57'sh0);
		q   = adj[56:33];
		if (q > 24'sh007FFF) begin
			return 16'sh7FFF;
		end else if (q < -24'sh008000) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	function automatic logic [14:0] sat_extent(input logic [52:0] p);
		return (|p[52:47]) ? 15'h7FFF : p[46:32];
	endfunction

	assign out_free = ~result_valid_q | ~result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqd_pkg::BK_IDLE: begin
				if (!empty) begin
					state_d = dqd_pkg::BK_MUL1;
				end
			end
			dqd_pkg::BK_MUL1: state_d = dqd_pkg::BK_MUL2;
			dqd_pkg::BK_MUL2: state_d = dqd_pkg::BK_FIN;
			dqd_pkg::BK_FIN: begin
				if (out_free) begin
					state_d = dqd_pkg::BK_IDLE;
				end
			end
			default: state_d = dqd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == dqd_pkg::BK_IDLE) && !empty;
		load_out = (state_q == dqd_pkg::BK_FIN) && out_free;
	end

	assign dx = $signed({1'b0, job_q.center_x, 1'b0}) - $signed({2'b00, job_q.box_w});
	assign dy = $signed({1'b0, job_q.center_y, 1'b0}) - $signed({2'b00, job_q.box_h});

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == dqd_pkg::BK_MUL1) begin
			lx_p1_q <= dx * $signed({1'b0, cfg.input_width});
			ty_p1_q <= dy * $signed({1'b0, cfg.input_height});
			wx_p1_q <= job_q.box_w * cfg.input_width;
			hy_p1_q <= job_q.box_h * cfg.input_height;
		end
		if (state_q == dqd_pkg::BK_MUL2) begin
			lx_p2_q <= lx_p1_q * $signed({1'b0, cfg.scale_x});
			ty_p2_q <= ty_p1_q * $signed({1'b0, cfg.scale_y});
			wx_p2_q <= wx_p1_q * cfg.scale_x;
			hy_p2_q <= hy_p1_q * cfg.scale_y;
		end
		if (load_out) begin
			result_q.det_class  <= job_q.det_class;
			result_q.confidence <= job_q.confidence;
			result_q.left       <= sat_corner(lx_p2_q);
			result_q.top        <= sat_corner(ty_p2_q);
			result_q.width_px   <= sat_extent(wx_p2_q);
			result_q.height_px  <= sat_extent(hy_p2_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dqd_pkg::BK_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ===== hw/rtl/detection_query_decode.sv =====
// Throughput: one class logit per cycle unless the front stalls; each query's box decode holds
//   the back part through MUL1, MUL2 and FIN. Path: the last logit passes the lookup and
//   score stages, the queue, MUL1, MUL2 and FIN, waiting while the back part or output is busy.
// The front stalls only when the 4-entry queue has no room for the queries in flight.
// Reset: arst_n clears all control state and loads register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module detection_query_decode #(
	parameter int MAX_CLASSES = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire dqd_pkg::in_item_t               item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output dqd_pkg::out_item_t                   result,
	input  wire logic                            cfg_wr_en,
	input  wire logic [dqd_pkg::CfgAddrW-1:0]    cfg_addr,
	input  wire logic [dqd_pkg::CfgDataW-1:0]    cfg_wdata
);

	// Configuration registers; the user must write them only while the block is idle (the block
	// itself does not enforce this), so both halves read them directly.
	dqd_pkg::cfg_t cfg_q;

	// Front to queue to back
	logic                          push;
	dqd_pkg::job_t                 push_data;
	logic                          pop;
	dqd_pkg::job_t                 head;
	logic                          empty;
	logic [dqd_pkg::QCntW-1:0]     q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_width     <= dqd_pkg::INPUT_WIDTH_RST;
			cfg_q.input_height    <= dqd_pkg::INPUT_HEIGHT_RST;
			cfg_q.scale_x         <= dqd_pkg::SCALE_X_RST;
			cfg_q.scale_y         <= dqd_pkg::SCALE_Y_RST;
			cfg_q.score_threshold <= dqd_pkg::SCORE_THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			// unknown indexes drop silently
			unique case (cfg_addr)
				dqd_pkg::CFG_INPUT_WIDTH:     cfg_q.input_width     <= cfg_wdata[12:0];
				dqd_pkg::CFG_INPUT_HEIGHT:    cfg_q.input_height    <= cfg_wdata[12:0];
				dqd_pkg::CFG_SCALE_X:         cfg_q.scale_x         <= cfg_wdata[23:0];
				dqd_pkg::CFG_SCALE_Y:         cfg_q.scale_y         <= cfg_wdata[23:0];
				dqd_pkg::CFG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Front: sigmoid lookup, running arg-max, threshold and background filter
	dqd_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.score_threshold (cfg_q.score_threshold),
		.q_count         (q_count),
		.push            (push),
		.push_data       (push_data)
	);

	// Queue of detections waiting for box decode
	dqd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (q_count)
	);

	// Back: box scaling, truncation and saturation, output register
	dqd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/dqd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "detection_query_decode_assert.svh"
module dqd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_stall,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire dqd_pkg::out_item_t result
);

	// hold a stalled result transaction
	`DQD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(result))

	// a kept score lies between the sigmoid floor and ceiling
	`DQD_ASSERT_IMPLY(a_conf_range, result_valid,
		(result.confidence >= 16'd22) && (result.confidence <= 16'd65514))

	// nothing comes out right after reset
	`DQD_ASSERT_IMPLY(a_no_result_after_reset, !$past(arst_n), !result_valid)

	// queue is empty after reset, so input is open
	`DQD_ASSERT_IMPLY(a_open_after_reset, !$past(arst_n), !item_stall)

endmodule

bind detection_query_decode dqd_checker u_dqd_checker (.*);
`default_nettype wire

// ===== tb/tb_detection_query_decode.sv =====
`timescale 1ns / 1ps
module tb_detection_query_decode;
	import dqd_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int MAX_CLASSES    = 128;
	// Covers the result latency with margin, for queries that emit nothing
	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 48;
	// Index outside the register map; the block must ignore it
	localparam logic [CfgAddrW-1:0] CFG_UNUSED = 3'd7;
	localparam longint CORNER_DIV = 64'sd1 << 33;
	localparam longint EXTENT_DIV = 64'sd1 << 32;

	// round(65536 * sigmoid(k/4)), k = 0..32
	localparam int unsigned SIGMOID_Q16 [0:32] = '{
		32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
		57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
		64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
		65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
		65514
	};

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed table: a register write or one logit transaction.
	// Pinned rows carry a hand-computed detection (or the absence of one).
	typedef struct {
		row_kind_t           kind;
		logic [CfgAddrW-1:0] addr;
		logic [CfgDataW-1:0] data;
		in_item_t            beat;
		bit                  pinned;
		bit                  pin_has;
		out_item_t           pin_det;
	} stim_row_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_item_t           result;
	logic                cfg_wr_en    = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr     = '0;
	logic [CfgDataW-1:0] cfg_wdata    = '0;

	// Register shadow and running per-query state of the decoder model
	int unsigned cfg_w   = 32'(INPUT_WIDTH_RST);
	int unsigned cfg_h   = 32'(INPUT_HEIGHT_RST);
	int unsigned cfg_sx  = 32'(SCALE_X_RST);
	int unsigned cfg_sy  = 32'(SCALE_Y_RST);
	int unsigned cfg_thr = 32'(SCORE_THRESHOLD_RST);
	int unsigned run_best_score = 0;
	int unsigned run_best_class = 32'(NO_CLASS);
	int unsigned run_count      = 0;

	out_item_t pending_dets [$];
	stim_row_t stim_rows [$];

	int err_cnt       = 0;
	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	// Bumped by the main sequence; the receiver serves each bump with one long hold
	int hold_requests = 0;

	detection_query_decode #(.MAX_CLASSES(MAX_CLASSES)) u_top (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result,
		.cfg_wr_en,
		.cfg_addr,
		.cfg_wdata
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Sigmoid table lookup with linear interpolation, symmetric about zero
	function automatic int unsigned sigmoid_q16(logic signed [15:0] lg);
		int mag;
		int idx;
		int frac;
		int unsigned s;
		mag = (lg < 0) ? -int'(lg) : int'(lg);
		if (mag >= 2048) begin
			s = SIGMOID_Q16[32];
		end else begin
			idx  = mag >> 6;
			frac = mag & 63;
			s = SIGMOID_Q16[idx] + (((SIGMOID_Q16[idx + 1] - SIGMOID_Q16[idx]) * frac) >> 6);
		end
		return (lg < 0) ? 65536 - s : s;
	endfunction

	// Box corner: (2c - size) * dim * scale / 2^33, truncated toward zero, saturated
	function automatic logic [15:0] corner_px(longint c, longint size, longint dim,
			longint scale);
		longint n;
		n = (2 * c - size) * dim * scale / CORNER_DIV;
		if (n < -32768) n = -32768;
		else if (n > 32767) n = 32767;
		return n[15:0];
	endfunction

	// Box extent: size * dim * scale / 2^32, clamped to the 15-bit field
	function automatic logic [14:0] extent_px(longint size, longint dim, longint scale);
		longint n;
		n = size * dim * scale / EXTENT_DIV;
		if (n > 32767) n = 32767;
		return n[14:0];
	endfunction

	// Advance the decoder model by one logit; report the detection it produces, if any
	function automatic void predict_detection(in_item_t b, output bit has, output out_item_t det);
		int unsigned s;
		has = 1'b0;
		det = '0;
		// Logits past the class limit are dropped and the count holds
		if (run_count < MAX_CLASSES) begin
			s = sigmoid_q16(b.logit);
			// Strictly greater: on a tie the earlier class stays
			if (s > run_best_score) begin
				run_best_score = s;
				run_best_class = run_count;
			end
			run_count++;
		end
		if (b.last_class) begin
			// Background (class 0) or a weak score emits nothing
			if (run_best_class != NO_CLASS && run_best_class != 0 && run_best_score >= cfg_thr) begin
				has = 1'b1;
				det.det_class  = 7'(run_best_class - 1);
				det.confidence = 16'(run_best_score);
				det.left       = corner_px(b.center_x, b.box_w, cfg_w, cfg_sx);
				det.top        = corner_px(b.center_y, b.box_h, cfg_h, cfg_sy);
				det.width_px   = extent_px(b.box_w, cfg_w, cfg_sx);
				det.height_px  = extent_px(b.box_h, cfg_h, cfg_sy);
			end
			run_best_score = 0;
			run_best_class = 32'(NO_CLASS);
			run_count      = 0;
		end
	endfunction

	function automatic in_item_t beat(logic [15:0] lg, bit last, logic [15:0] cx,
			logic [15:0] cy, logic [15:0] bw, logic [15:0] bh);
		in_item_t b;
		b.logit      = lg;
		b.last_class = last;
		b.center_x   = cx;
		b.center_y   = cy;
		b.box_w      = bw;
		b.box_h      = bh;
		return b;
	endfunction

	function automatic void add_row(row_kind_t kind, logic [CfgAddrW-1:0] a,
			logic [CfgDataW-1:0] d, in_item_t b, bit pinned, bit has, out_item_t det);
		stim_row_t r;
		r.kind    = kind;
		r.addr    = a;
		r.data    = d;
		r.beat    = b;
		r.pinned  = pinned;
		r.pin_has = has;
		r.pin_det = det;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	function automatic void add_cfg(logic [CfgAddrW-1:0] a, logic [CfgDataW-1:0] d);
		add_row(ROW_CFG, a, d, '0, 1'b0, 1'b0, '0);
	endfunction

	function automatic void add_item(in_item_t b);
		add_row(ROW_ITEM, '0, '0, b, 1'b0, 1'b0, '0);
	endfunction

	function automatic void add_pinned(in_item_t b, bit has, out_item_t det);
		add_row(ROW_ITEM, '0, '0, b, 1'b1, has, det);
	endfunction

	function automatic void build_directed();
		// Reset registers: 640 px input, unity scale, threshold one half.
		// Class 1 saturates high; a centered box with no size lands on 320, 320.
		add_item(beat(16'h0000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h7FFF, 1'b1, 16'h8000, 16'h8000, 0, 0), 1'b1,
			out_item_t'{7'd0, 16'd65514, 16'd320, 16'd320, 15'd0, 15'd0});
		// Background wins: nothing comes out, the query still clears
		add_item(beat(16'h7FFF, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h0000, 1'b1, 16'h8000, 16'h8000, 0, 0), 1'b0, '0);
		// Tie between class 0 and class 1: the first one is kept
		add_item(beat(16'h0100, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h0100, 1'b1, 16'h8000, 16'h8000, 0, 0), 1'b0, '0);
		// Single-logit query: only background can win
		add_pinned(beat(16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
		// Most negative logits, then class 2 at exactly one half
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_item(beat(16'h0000, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF));
		// Score equal to the threshold passes
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h0000, 1'b1, 16'h8000, 16'h8000, 0, 0), 1'b1,
			out_item_t'{7'd0, 16'd32768, 16'd320, 16'd320, 15'd0, 15'd0});
		// One step below the threshold fails
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'hFFFF, 1'b1, 16'h8000, 16'h8000, 0, 0), 1'b0, '0);
		// Interpolation, negative side, and the table edge just under and at 8.0
		add_item(beat(16'hFEDD, 1'b0, 0, 0, 0, 0));
		add_item(beat(16'h07FF, 1'b0, 0, 0, 0, 0));
		add_item(beat(16'h0800, 1'b1, 16'h4000, 16'hC000, 16'h2000, 16'h1000));

		// Widest input and scale, threshold zero: every box field saturates
		add_cfg(CFG_INPUT_WIDTH, 24'd8191);
		add_cfg(CFG_INPUT_HEIGHT, 24'd8191);
		add_cfg(CFG_SCALE_X, 24'hFFFFFF);
		add_cfg(CFG_SCALE_Y, 24'hFFFFFF);
		add_cfg(CFG_SCORE_THRESHOLD, 24'd0);
		add_cfg(CFG_UNUSED, 24'hFFFFFF);
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, 0, 0), 1'b1,
			out_item_t'{7'd0, 16'd32768, 16'h7FFF, 16'h7FFF, 15'd0, 15'd0});
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h0000, 1'b1, 0, 0, 16'hFFFF, 16'hFFFF), 1'b1,
			out_item_t'{7'd0, 16'd32768, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF});

		// Zero input size: boxes collapse to zero
		add_cfg(CFG_INPUT_WIDTH, 24'd0);
		add_cfg(CFG_INPUT_HEIGHT, 24'd0);
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
			out_item_t'{7'd0, 16'd65514, 16'd0, 16'd0, 15'd0, 15'd0});

		// Zero scale and the top threshold: the best reachable score is rejected
		add_cfg(CFG_INPUT_WIDTH, 24'd640);
		add_cfg(CFG_INPUT_HEIGHT, 24'd640);
		add_cfg(CFG_SCALE_X, 24'd0);
		add_cfg(CFG_SCALE_Y, 24'd0);
		add_cfg(CFG_SCORE_THRESHOLD, 24'd65535);
		add_item(beat(16'h8000, 1'b0, 0, 0, 0, 0));
		add_pinned(beat(16'h7FFF, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, '0);
	endfunction

	function automatic logic [15:0] box_extreme();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic void note_error(string what, longint want_v, longint got_v);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
	endfunction

	// Compare one accepted detection against the oldest outstanding one
	function automatic void check_detection(out_item_t got);
		out_item_t want;
		if (pending_dets.size() == 0) begin
			note_error("det_class of a detection with none pending", -1, got.det_class);
			return;
		end
		want = pending_dets.pop_front();
		if (got.det_class !== want.det_class)
			note_error("det_class", want.det_class, got.det_class);
		if (got.confidence !== want.confidence)
			note_error("confidence", want.confidence, got.confidence);
		if (got.left !== want.left) note_error("left", want.left, got.left);
		if (got.top !== want.top) note_error("top", want.top, got.top);
		if (got.width_px !== want.width_px) note_error("width_px", want.width_px, got.width_px);
		if (got.height_px !== want.height_px)
			note_error("height_px", want.height_px, got.height_px);
	endfunction

	// Offer one logit transaction, hold it until accepted, then advance the model
	task automatic send_item(input in_item_t b, output bit has, output out_item_t det);
		while ($urandom_range(99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_detection(b, has, det);
	endtask

	// Drop valid and wait for the block to go quiet before touching registers
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_dets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller drops the write enable after the last one
	task automatic write_reg(logic [CfgAddrW-1:0] a, logic [CfgDataW-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= d;
		@(posedge clk);
		case (a)
			CFG_INPUT_WIDTH:     cfg_w   = 32'(d[12:0]);
			CFG_INPUT_HEIGHT:    cfg_h   = 32'(d[12:0]);
			CFG_SCALE_X:         cfg_sx  = 32'(d[23:0]);
			CFG_SCALE_Y:         cfg_sy  = 32'(d[23:0]);
			CFG_SCORE_THRESHOLD: cfg_thr = 32'(d[15:0]);
			default: ;
		endcase
	endtask

	task automatic load_regs(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h,
			logic [CfgDataW-1:0] sx, logic [CfgDataW-1:0] sy, logic [CfgDataW-1:0] thr);
		settle();
		write_reg(CFG_INPUT_WIDTH, w);
		write_reg(CFG_INPUT_HEIGHT, h);
		write_reg(CFG_SCALE_X, sx);
		write_reg(CFG_SCALE_Y, sy);
		write_reg(CFG_SCORE_THRESHOLD, thr);
		write_reg(CFG_UNUSED, 24'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// Moderate random settings: boxes mostly stay inside the 16-bit range
	task automatic random_regs();
		load_regs(24'($urandom_range(1, 4096)), 24'($urandom_range(1, 4096)),
			24'($urandom_range(16384, 196608)), 24'($urandom_range(16384, 196608)),
			24'($urandom_range(16384, 49152)));
	endtask

	// One query of n logits. Eager queries lead with a negative logit and follow
	// with positive ones, so a foreground class nearly always wins.
	task automatic send_query(int n, bit eager);
		in_item_t b;
		bit has;
		out_item_t det;
		logic [15:0] prev;
		prev = '0;
		for (int k = 0; k < n; k++) begin
			if (n > MAX_CLASSES) begin
				// Overlong query: the strong tail past the class limit must be ignored
				b.logit = (k >= MAX_CLASSES) ? 16'h7FFF : 16'($urandom_range(600)) - 16'd300;
			end else if (eager) begin
				b.logit = (k == 0) ? {1'b1, 15'($urandom)} : {1'b0, 15'($urandom)};
			end else begin
				case ($urandom_range(9))
					0, 1, 2, 3: b.logit = 16'($urandom);
					4, 5: b.logit = 16'($urandom_range(600)) - 16'd300;
					6: b.logit = prev;
					7: b.logit = $urandom_range(1) ? 16'h7FFF : 16'h8000;
					default: b.logit = {1'b0, 15'($urandom)};
				endcase
			end
			prev = b.logit;
			b.last_class = (k == n - 1);
			if (b.last_class && $urandom_range(3) == 0) begin
				b.center_x = box_extreme();
				b.center_y = box_extreme();
				b.box_w    = box_extreme();
				b.box_h    = box_extreme();
			end else begin
				b.center_x = 16'($urandom);
				b.center_y = 16'($urandom);
				b.box_w    = 16'($urandom);
				b.box_h    = 16'($urandom);
			end
			send_item(b, has, det);
			if (has) pending_dets.insert(pending_dets.size(), det);
		end
	endtask

	task automatic run_phase(int snd_pct, int rcv_pct, bit eager, bit with_long);
		int sent;
		int n;
		int r;
		snd_idle_pct  = snd_pct;
		rcv_stall_pct = rcv_pct;
		sent = 0;
		if (with_long) begin
			n = $urandom_range(MAX_CLASSES + 1, MAX_CLASSES + 10);
			send_query(n, 1'b0);
			sent += n;
		end
		while (sent < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (eager) n = $urandom_range(2, 4);
			else if (r < 1) n = $urandom_range(MAX_CLASSES + 1, MAX_CLASSES + 12);
			else if (r < 15) n = 1;
			else n = $urandom_range(2, 8);
			send_query(n, eager);
			sent += n;
		end
	endtask

	// Result side: check each accepted transaction, then pick the next stall
	initial begin
		int hold_cnt;
		int hold_served;
		hold_cnt    = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) check_detection(result);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_cnt    = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
			else quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// Main sequence: reset, directed table, then random phases
	initial begin
		bit has;
		out_item_t det;
		bit cfg_open;
		cfg_open = 1'b0;
		build_directed();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct  = 28;
		rcv_stall_pct = 28;
		foreach (stim_rows[idx]) begin
			if (stim_rows[idx].kind == ROW_CFG) begin
				if (!cfg_open) settle();
				cfg_open = 1'b1;
				write_reg(stim_rows[idx].addr, stim_rows[idx].data);
			end else begin
				if (cfg_open) cfg_wr_en <= 1'b0;
				cfg_open = 1'b0;
				send_item(stim_rows[idx].beat, has, det);
				// Pinned rows use the hand-computed outcome in place of the model's
				if (stim_rows[idx].pinned) begin
					if (stim_rows[idx].pin_has)
						pending_dets.insert(pending_dets.size(), stim_rows[idx].pin_det);
				end else if (has) begin
					pending_dets.insert(pending_dets.size(), det);
				end
			end
		end

		load_regs(24'(INPUT_WIDTH_RST), 24'(INPUT_HEIGHT_RST), SCALE_X_RST, SCALE_Y_RST,
			24'(SCORE_THRESHOLD_RST));
		run_phase(0, 0, 1'b0, 1'b1);
		random_regs();
		run_phase(59, 0, 1'b0, 1'b0);
		random_regs();
		run_phase(0, 59, 1'b0, 1'b0);
		random_regs();
		run_phase(28, 28, 1'b0, 1'b0);

		// Back-pressure: hold the result side while eager queries stream in,
		// so the decode queue fills and the front stalls its input
		load_regs(24'(INPUT_WIDTH_RST), 24'(INPUT_HEIGHT_RST), SCALE_X_RST, SCALE_Y_RST,
			24'(SCORE_THRESHOLD_RST));
		hold_requests++;
		run_phase(0, 0, 1'b1, 1'b0);

		load_regs(24'd8191, 24'd1, 24'hFFFFFF, 24'd0, 24'd0);
		run_phase(59, 0, 1'b0, 1'b0);
		load_regs(24'd1, 24'd4096, 24'd1, 24'h800000, 24'd65514);
		run_phase(0, 59, 1'b0, 1'b0);
		random_regs();
		run_phase(28, 28, 1'b0, 1'b0);

		// Drain every outstanding detection, then let the pipeline run dry
		settle();
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
